/* hdl/cht_pkg.sv */
// cht_pkg: shared types, codes and defaults for the chained hash table engine
// no dependencies; imported by cht_front, cht_back and the core top level
package cht_pkg;

	localparam int DEF_MAX_BUCKETS      = 64;
	localparam int DEF_SLOTS_PER_BUCKET = 8;
	localparam int DEF_START_BUCKETS    = 4;
	localparam int DEF_LOAD_DIVISOR     = 4;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_ERASE  = 2'd2;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_FOUND     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_ERASED    = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_LOOKUP,
		OP_ERASE,
		OP_NOP
	} cht_op_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] key;
		logic [63:0] value;
	} cht_cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] value_out;
		logic [9:0]  entry_count;
		logic [6:0]  bucket_count;
	} cht_rsp_t;

	typedef struct packed {
		cht_op_t     op;
		logic [63:0] key;
		logic [63:0] value;
	} cht_work_t;

endpackage

/* hdl/cht_front.sv */
// cht_front: accepts command words, decodes the command and queues the work
// depends on cht_pkg
module cht_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cht_pkg::cht_cmd_t    cmd,
	output logic                 work_valid,
	output cht_pkg::cht_work_t   work,
	input  logic                 work_pop
);
	import cht_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cht_work_t       q_mem [QUEUE_DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;
	cht_work_t       decoded;
	logic            push;

	always_comb begin
		decoded.key   = cmd.key;
		decoded.value = cmd.value;
		unique case (cmd.command)
			CMD_INSERT: decoded.op = OP_INSERT;
			CMD_LOOKUP: decoded.op = OP_LOOKUP;
			CMD_ERASE:  decoded.op = OP_ERASE;
			default:    decoded.op = OP_NOP;
		endcase
	end

	assign cmd_stall  = (cnt_q == CW'(QUEUE_DEPTH));
	assign push       = cmd_valid && !cmd_stall;
	assign work_valid = (cnt_q != '0);
	assign work       = q_mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wp_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wp_q + 1'b1);
			end
			if (work_pop) begin
				rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rp_q + 1'b1);
			end
			if (push && !work_pop) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (!push && work_pop) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

endmodule

/* hdl/cht_back.sv */
// cht_back: sequencer that scans buckets, rehashes on growth and answers
// depends on cht_pkg; holds the slot key/value memories and bucket fills
module cht_back #(
	parameter int MAX_BUCKETS      = cht_pkg::DEF_MAX_BUCKETS,
	parameter int SLOTS_PER_BUCKET = cht_pkg::DEF_SLOTS_PER_BUCKET,
	parameter int START_BUCKETS    = cht_pkg::DEF_START_BUCKETS,
	parameter int LOAD_DIVISOR     = cht_pkg::DEF_LOAD_DIVISOR
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 work_valid,
	input  cht_pkg::cht_work_t   work,
	output logic                 work_pop,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output cht_pkg::cht_rsp_t    rsp
);
	import cht_pkg::*;

	localparam int TOTAL = MAX_BUCKETS * SLOTS_PER_BUCKET;
	localparam int AW    = $clog2(TOTAL);
	localparam int BW    = $clog2(MAX_BUCKETS);
	localparam int CW    = $clog2(MAX_BUCKETS + 1);
	localparam int IW    = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int EW    = $clog2(TOTAL + 1);
	localparam int NLVL  = $clog2(MAX_BUCKETS) + 1;
	localparam int LW    = $clog2(NLVL);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b0_0000_0001,
		S_GROW  = 9'b0_0000_0010,
		S_GNEXT = 9'b0_0000_0100,
		S_SET   = 9'b0_0000_1000,
		S_SCAN  = 9'b0_0001_0000,
		S_ACT   = 9'b0_0010_0000,
		S_ERD   = 9'b0_0100_0000,
		S_DONE  = 9'b0_1000_0000,
		S_CLR   = 9'b1_0000_0000
	} state_t;

	state_t          state_q;
	cht_op_t         op_q;
	logic [63:0]     key_q;
	logic [63:0]     val_q;
	logic [63:0]     vout_q;
	logic [2:0]      status_q;
	logic [BW-1:0]   b_q;
	logic [IW-1:0]   widx_q;
	logic [IW-1:0]   pidx_q;
	logic [IW-1:0]   sidx_q;
	logic [IW-1:0]   nl_q;
	logic [IW-1:0]   nh_q;
	logic            pend_q;
	logic            hit_q;
	logic [CW-1:0]   cap_q;
	logic [LW-1:0]   lvl_q;
	logic [EW-1:0]   stored_q;
	logic            rsp_valid_q;
	cht_rsp_t        rsp_q;

	logic [63:0]     key_mem [TOTAL];
	logic [63:0]     val_mem [TOTAL];
	logic [63:0]     rkey_q;
	logic [63:0]     rval_q;

	logic [IW-1:0]   fill_mem [MAX_BUCKETS];
	logic [IW-1:0]   fill_rd_q;
	logic [BW-1:0]   fill_ra;
	logic            fwr_a;
	logic [BW-1:0]   fwa_a;
	logic [IW-1:0]   fwd_a;
	logic            fwr_b;
	logic [BW-1:0]   fwa_b;
	logic [IW-1:0]   fwd_b;
	logic [BW-1:0]   bkt_now;
	logic [BW-1:0]   bkt_grown;
	logic            last_b;

	logic [EW-1:0]   thr_w   [NLVL];
	logic            grow_ok [NLVL];

	logic [IW-1:0]   fill_cur;
	logic [BW-1:0]   hb;
	logic [AW-1:0]   base;
	logic [AW-1:0]   hbase;
	logic [AW-1:0]   raddr;
	logic [AW-1:0]   waddr;
	logic            wr_key;
	logic            wr_val;
	logic [63:0]     wdata_key;
	logic [63:0]     wdata_val;
	logic            split_hi;
	logic            scan_hit;
	logic            need_grow;

	// load threshold and growth limit per doubling level, fixed at elaboration
	for (genvar g = 0; g < NLVL; g++) begin : g_lvl
		localparam int CapG = START_BUCKETS << g;
		assign thr_w[g]   = EW'(CapG - CapG / LOAD_DIVISOR);
		assign grow_ok[g] = (CapG * 2 <= MAX_BUCKETS);
	end

	assign fill_cur  = fill_rd_q;
	assign hb        = BW'(CW'(b_q) + cap_q);
	assign base      = AW'(b_q) * AW'(SLOTS_PER_BUCKET);
	assign hbase     = AW'(hb) * AW'(SLOTS_PER_BUCKET);
	assign split_hi  = (rkey_q & 64'(cap_q)) != '0;
	assign scan_hit  = pend_q && (rkey_q == key_q);
	assign need_grow = (work.op == OP_INSERT) && (stored_q >= thr_w[lvl_q]) && grow_ok[lvl_q];
	assign work_pop  = (state_q == S_IDLE) && work_valid;

	assign bkt_now   = BW'(work.key & 64'(CW'(cap_q - 1'b1)));
	assign bkt_grown = BW'(key_q & 64'(CW'((cap_q << 1) - 1'b1)));
	assign last_b    = (CW'(b_q) == CW'(cap_q - 1'b1));

	// bucket that b_q holds next cycle; its fill is read ahead so fill_rd_q matches b_q
	always_comb begin
		fill_ra = b_q;
		if (state_q == S_CLR) begin
			fill_ra = (b_q == BW'(MAX_BUCKETS - 1)) ? '0 : BW'(b_q + 1'b1);
		end else if (state_q == S_IDLE && work_valid) begin
			fill_ra = need_grow ? '0 : bkt_now;
		end else if (state_q == S_GNEXT) begin
			fill_ra = last_b ? bkt_grown : BW'(b_q + 1'b1);
		end
	end

	always_comb begin
		fwr_a = 1'b0;
		fwa_a = b_q;
		fwd_a = '0;
		fwr_b = 1'b0;
		fwa_b = hb;
		fwd_b = nh_q;
		case (state_q)
			S_CLR: begin
				fwr_a = 1'b1;
			end
			S_GNEXT: begin
				fwr_a = 1'b1;
				fwd_a = nl_q;
				fwr_b = 1'b1;
			end
			S_ACT: begin
				if (op_q == OP_INSERT && !hit_q && fill_cur < IW'(SLOTS_PER_BUCKET)) begin
					fwr_a = 1'b1;
					fwd_a = IW'(fill_cur + 1'b1);
				end
			end
			S_ERD: begin
				fwr_a = 1'b1;
				fwd_a = IW'(fill_cur - 1'b1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fwr_a) begin
			fill_mem[fwa_a] <= fwd_a;
		end
		if (fwr_b) begin
			fill_mem[fwa_b] <= fwd_b;
		end
	end

	// registered fill read with bypass of a same-cycle write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_rd_q <= '0;
		end else if (fwr_a && fwa_a == fill_ra) begin
			fill_rd_q <= fwd_a;
		end else if (fwr_b && fwa_b == fill_ra) begin
			fill_rd_q <= fwd_b;
		end else begin
			fill_rd_q <= fill_mem[fill_ra];
		end
	end

	always_comb begin
		raddr     = base + AW'(widx_q);
		wr_key    = 1'b0;
		wr_val    = 1'b0;
		waddr     = base + AW'(sidx_q);
		wdata_key = key_q;
		wdata_val = val_q;
		if (state_q == S_GROW && pend_q) begin
			wr_key    = 1'b1;
			wr_val    = 1'b1;
			wdata_key = rkey_q;
			wdata_val = rval_q;
			waddr     = split_hi ? hbase + AW'(nh_q) : base + AW'(nl_q);
		end else if (state_q == S_ACT) begin
			// erase fetches the bucket's last pair to fill the hole
			raddr = base + AW'(IW'(fill_cur - 1'b1));
			if (op_q == OP_INSERT) begin
				if (hit_q) begin
					wr_val = 1'b1;
				end else if (fill_cur < IW'(SLOTS_PER_BUCKET)) begin
					wr_key = 1'b1;
					wr_val = 1'b1;
					waddr  = base + AW'(fill_cur);
				end
			end
		end else if (state_q == S_ERD) begin
			wr_key    = 1'b1;
			wr_val    = 1'b1;
			wdata_key = rkey_q;
			wdata_val = rval_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_key) begin
			key_mem[waddr] <= wdata_key;
		end
		if (wr_val) begin
			val_mem[waddr] <= wdata_val;
		end
		rkey_q <= key_mem[raddr];
		rval_q <= val_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			op_q        <= OP_NOP;
			key_q       <= '0;
			val_q       <= '0;
			vout_q      <= '0;
			status_q    <= ST_NOT_FOUND;
			b_q         <= '0;
			widx_q      <= '0;
			pidx_q      <= '0;
			sidx_q      <= '0;
			nl_q        <= '0;
			nh_q        <= '0;
			pend_q      <= 1'b0;
			hit_q       <= 1'b0;
			cap_q       <= CW'(START_BUCKETS);
			lvl_q       <= '0;
			stored_q    <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			b_q <= fill_ra;
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					if (b_q == BW'(MAX_BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (work_valid) begin
						op_q     <= work.op;
						key_q    <= work.key;
						val_q    <= work.value;
						vout_q   <= '0;
						status_q <= ST_NOT_FOUND;
						if (work.op == OP_NOP) begin
							state_q <= S_DONE;
						end else if (need_grow) begin
							widx_q  <= '0;
							pend_q  <= 1'b0;
							nl_q    <= '0;
							nh_q    <= '0;
							state_q <= S_GROW;
						end else begin
							state_q <= S_SET;
						end
					end
				end
				S_GROW: begin
					if (pend_q) begin
						if (split_hi) begin
							nh_q <= IW'(nh_q + 1'b1);
						end else begin
							nl_q <= IW'(nl_q + 1'b1);
						end
					end
					if (widx_q < fill_cur) begin
						pend_q <= 1'b1;
						widx_q <= IW'(widx_q + 1'b1);
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= S_GNEXT;
						end
					end
				end
				S_GNEXT: begin
					widx_q <= '0;
					nl_q   <= '0;
					nh_q   <= '0;
					if (last_b) begin
						cap_q   <= CW'(cap_q << 1);
						lvl_q   <= LW'(lvl_q + 1'b1);
						state_q <= S_SET;
					end else begin
						state_q <= S_GROW;
					end
				end
				S_SET: begin
					widx_q  <= '0;
					pend_q  <= 1'b0;
					hit_q   <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// reads are issued one per cycle, each compared in the cycle after
					if (scan_hit) begin
						hit_q  <= 1'b1;
						sidx_q <= pidx_q;
						pend_q <= 1'b0;
						if (op_q == OP_LOOKUP) begin
							vout_q <= rval_q;
						end
						state_q <= S_ACT;
					end else if (widx_q < fill_cur) begin
						pend_q <= 1'b1;
						pidx_q <= widx_q;
						widx_q <= IW'(widx_q + 1'b1);
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					state_q <= S_DONE;
					unique case (op_q)
						OP_INSERT: begin
							if (hit_q) begin
								status_q <= ST_UPDATED;
							end else if (fill_cur >= IW'(SLOTS_PER_BUCKET)) begin
								status_q <= ST_FULL;
							end else begin
								stored_q <= EW'(stored_q + 1'b1);
								status_q <= ST_INSERTED;
							end
						end
						OP_LOOKUP: begin
							status_q <= hit_q ? ST_FOUND : ST_NOT_FOUND;
						end
						OP_ERASE: begin
							if (hit_q) begin
								state_q <= S_ERD;
							end else begin
								status_q <= ST_NOT_FOUND;
							end
						end
						default: begin
							status_q <= ST_NOT_FOUND;
						end
					endcase
				end
				S_ERD: begin
					stored_q <= EW'(stored_q - 1'b1);
					status_q <= ST_ERASED;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q        <= 1'b1;
						rsp_q.status       <= status_q;
						rsp_q.value_out    <= vout_q;
						rsp_q.entry_count  <= 10'(stored_q);
						rsp_q.bucket_count <= 7'(cap_q);
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cap_q >= CW'(START_BUCKETS)) && (cap_q <= CW'(MAX_BUCKETS)))
		else $error("bucket count out of range");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLR) |-> (fill_cur <= IW'(SLOTS_PER_BUCKET)))
		else $error("bucket fill above slot count");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (widx_q <= fill_cur))
		else $error("scan index ran past bucket fill");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !(rsp_valid_q && rsp_stall)) |=> (rsp_valid_q && state_q == S_IDLE))
		else $error("finished result not presented");

endmodule

/* hdl/chained_hash_table_engine_core.sv */
// Chained hash table engine: 64-bit keys map to 64-bit values in buckets of
// SLOTS_PER_BUCKET slots; the bucket is the key masked by the active bucket
// count minus one. That count doubles with a full rehash when an insert finds
// the table loaded and the doubled count fits in MAX_BUCKETS. A command scans
// its bucket one pair at a time, as the slot memory delivers one pair per
// cycle; an erase adds a step moving the bucket's last pair into the hole, and
// a doubling first walks every old bucket and splits its pairs. One command is
// worked at a time; a two-word queue takes new commands meanwhile and a result
// register holds the answer. After reset a pass over all MAX_BUCKETS buckets
// clears their fills before the first command; commands queue up meanwhile.
module chained_hash_table_engine_core #(
	parameter int MAX_BUCKETS      = cht_pkg::DEF_MAX_BUCKETS,
	parameter int SLOTS_PER_BUCKET = cht_pkg::DEF_SLOTS_PER_BUCKET,
	parameter int START_BUCKETS    = cht_pkg::DEF_START_BUCKETS,
	parameter int LOAD_DIVISOR     = cht_pkg::DEF_LOAD_DIVISOR
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  cht_pkg::cht_cmd_t  cmd,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output cht_pkg::cht_rsp_t  rsp
);
	import cht_pkg::*;

	cht_work_t work;
	logic      work_valid;
	logic      work_pop;

	cht_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.work_valid (work_valid),
		.work       (work),
		.work_pop   (work_pop)
	);

	cht_back #(
		.MAX_BUCKETS      (MAX_BUCKETS),
		.SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
		.START_BUCKETS    (START_BUCKETS),
		.LOAD_DIVISOR     (LOAD_DIVISOR)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_valid (work_valid),
		.work       (work),
		.work_pop   (work_pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule
